// ===== sv/stf_pkg.sv =====
// ----------------------------------------------------------------------------
// stf_pkg
// Shared constants for the sliding-window trimmed mean filter.
// ----------------------------------------------------------------------------
package stf_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int MIN_AVG_COUNT = 3;
   localparam int TRIM_COUNT    = 2;

endpackage

// ===== sv/stf_front.sv =====
// ----------------------------------------------------------------------------
// stf_front
// Takes requests, tracks the window fill level and tags each request as
// averaged or pass-through before it is queued.
// ----------------------------------------------------------------------------
module stf_front #(
   parameter int WINDOW_SIZE = 8,
   parameter int CNT_W       = $clog2(WINDOW_SIZE + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [stf_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic [stf_pkg::SAMPLE_W-1:0]  push_sample,
   output logic [CNT_W-1:0]              push_count,
   output logic                          push_averaged
);
   import stf_pkg::*;

   logic [CNT_W-1:0] fill_count_ff;
   logic [CNT_W-1:0] fill_count_in;
   logic             accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid & push_ready;

   always_comb begin
      if (fill_count_ff < CNT_W'(WINDOW_SIZE)) begin
         fill_count_in = fill_count_ff + CNT_W'(1);
      end else begin
         fill_count_in = fill_count_ff;
      end
   end

   assign push_sample   = req_sample;
   assign push_count    = fill_count_in;
   assign push_averaged = (fill_count_in >= CNT_W'(MIN_AVG_COUNT));

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else if (accept) begin
         fill_count_ff <= fill_count_in;
      end
   end

endmodule

// ===== sv/stf_queue.sv =====
// ----------------------------------------------------------------------------
// stf_queue
// Small register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module stf_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   import stf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [LVL_W-1:0]  level_ff;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (level_ff != LVL_W'(DEPTH));
   assign pop_valid  = (level_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            level_ff <= level_ff + LVL_W'(1);
         end else if (do_pop && !do_push) begin
            level_ff <= level_ff - LVL_W'(1);
         end
      end
   end

endmodule

// ===== sv/stf_back.sv =====
// ----------------------------------------------------------------------------
// stf_back
// Owns the sample window. Writes each queued sample; for an averaged request
// scans the window for sum, max and min and divides the trimmed sum
// bit-serially. Holds the result in an output register.
// ----------------------------------------------------------------------------
module stf_back #(
   parameter int WINDOW_SIZE = 8,
   parameter int CNT_W       = $clog2(WINDOW_SIZE + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  logic [stf_pkg::SAMPLE_W-1:0]  pop_sample,
   input  logic [CNT_W-1:0]              pop_count,
   input  logic                          pop_averaged,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [stf_pkg::SAMPLE_W-1:0]  rsp_filtered,
   output logic                          rsp_averaged
);
   import stf_pkg::*;

   localparam int IDX_W  = $clog2(WINDOW_SIZE);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int DCNT_W = $clog2(SUM_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type            state_ff;
   logic [SAMPLE_W-1:0]  mem [WINDOW_SIZE];
   logic [IDX_W-1:0]     wr_ptr_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 averaged_ff;
   logic [CNT_W-1:0]     issue_ff;
   logic                 rd_vld_ff;
   logic [SAMPLE_W-1:0]  rd_data_ff;
   logic                 first_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [SAMPLE_W-1:0]  hi_ff;
   logic [SAMPLE_W-1:0]  lo_ff;
   logic [CNT_W-1:0]     div_ff;
   logic [CNT_W-1:0]     rem_ff;
   logic [SUM_W-1:0]     quo_ff;
   logic [DCNT_W-1:0]    div_cnt_ff;
   logic                 rsp_valid_ff;
   logic [SAMPLE_W-1:0]  rsp_filtered_ff;
   logic                 rsp_averaged_ff;

   logic                 do_pop;
   logic                 do_issue;
   logic                 rsp_load;
   logic [CNT_W:0]       trial_in;
   logic                 trial_ge_in;
   logic [SUM_W-1:0]     trimmed_in;

   assign pop_ready    = (state_ff == ST_IDLE);
   assign do_pop       = pop_valid & pop_ready;
   assign do_issue     = (state_ff == ST_SCAN) && (issue_ff != count_ff);
   assign rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_averaged = rsp_averaged_ff;

   assign trial_in    = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ge_in = (trial_in >= {1'b0, div_ff});
   assign trimmed_in  = sum_ff - SUM_W'(hi_ff) - SUM_W'(lo_ff);

   // window store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_pop) begin
         mem[wr_ptr_ff] <= pop_sample;
      end
      if (do_issue) begin
         rd_data_ff <= mem[issue_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_vld_ff <= do_issue;
         case (state_ff)
            ST_IDLE: begin
               if (do_pop) begin
                  wr_ptr_ff   <= (wr_ptr_ff == IDX_W'(WINDOW_SIZE - 1)) ?
                                 '0 : wr_ptr_ff + IDX_W'(1);
                  count_ff    <= pop_count;
                  averaged_ff <= pop_averaged;
                  issue_ff    <= '0;
                  first_ff    <= 1'b1;
                  sum_ff      <= '0;
                  div_ff      <= pop_count - CNT_W'(TRIM_COUNT);
                  quo_ff      <= SUM_W'(pop_sample);
                  state_ff    <= pop_averaged ? ST_SCAN : ST_DONE;
               end
            end
            ST_SCAN: begin
               if (do_issue) begin
                  issue_ff <= issue_ff + CNT_W'(1);
               end
               if (rd_vld_ff) begin
                  first_ff <= 1'b0;
                  if (first_ff) begin
                     sum_ff <= SUM_W'(rd_data_ff);
                     hi_ff  <= rd_data_ff;
                     lo_ff  <= rd_data_ff;
                  end else begin
                     sum_ff <= sum_ff + SUM_W'(rd_data_ff);
                     if (rd_data_ff > hi_ff) begin
                        hi_ff <= rd_data_ff;
                     end
                     if (rd_data_ff < lo_ff) begin
                        lo_ff <= rd_data_ff;
                     end
                  end
               end else if (!do_issue && !first_ff) begin
                  quo_ff     <= trimmed_in;
                  rem_ff     <= '0;
                  div_cnt_ff <= DCNT_W'(SUM_W);
                  state_ff   <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (trial_ge_in) begin
                  rem_ff <= CNT_W'(trial_in - {1'b0, div_ff});
               end else begin
                  rem_ff <= trial_in[CNT_W-1:0];
               end
               quo_ff     <= {quo_ff[SUM_W-2:0], trial_ge_in};
               div_cnt_ff <= div_cnt_ff - DCNT_W'(1);
               if (div_cnt_ff == DCNT_W'(1)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_filtered_ff <= quo_ff[SAMPLE_W-1:0];
                  rsp_averaged_ff <= averaged_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== sv/sliding_trimmed_mean_filter_core.sv =====
// ----------------------------------------------------------------------------
// sliding_trimmed_mean_filter_core
// Sliding-window trimmed mean over the newest WINDOW_SIZE samples.
// ----------------------------------------------------------------------------
// Each request carries one 16-bit sample and yields one response. Once the
// window holds three or more samples the response is the window mean with one
// maximum and one minimum dropped (truncating), with rsp_averaged set; before
// that the sample passes through with rsp_averaged clear. Requests are taken
// into a two-entry queue, so the port keeps accepting while a response waits,
// until the queue is full. The back end handles one request at a time: a
// pass-through skips the window scan and the divide; an averaged one scans
// the window (one window memory read per cycle) and then divides bit-serially.
// ----------------------------------------------------------------------------
module sliding_trimmed_mean_filter_core #(
   parameter int WINDOW_SIZE = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [stf_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [stf_pkg::SAMPLE_W-1:0]  rsp_filtered,
   output logic                          rsp_averaged
);
   import stf_pkg::*;

   localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
   localparam int DATA_W = SAMPLE_W + CNT_W + 1;

   logic                push_valid;
   logic                push_ready;
   logic [SAMPLE_W-1:0] push_sample;
   logic [CNT_W-1:0]    push_count;
   logic                push_averaged;
   logic                pop_valid;
   logic                pop_ready;
   logic [DATA_W-1:0]   pop_data;

   stf_front #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .CNT_W       (CNT_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_sample   (push_sample),
      .push_count    (push_count),
      .push_averaged (push_averaged)
   );

   stf_queue #(
      .DATA_W (DATA_W),
      .DEPTH  (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_averaged, push_count, push_sample}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   stf_back #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .CNT_W       (CNT_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_sample   (pop_data[SAMPLE_W-1:0]),
      .pop_count    (pop_data[SAMPLE_W+CNT_W-1:SAMPLE_W]),
      .pop_averaged (pop_data[DATA_W-1]),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_filtered (rsp_filtered),
      .rsp_averaged (rsp_averaged)
   );

endmodule
